FILE: hw/rtl/tlpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_pkg: shared codes for the three-level priority FIFO
// Command and status codes, queue index type and level decoding.
// ----------------------------------------------------------------------------
package tlpf_pkg;

	localparam int NumLevels = 3;

	typedef logic [1:0] queue_idx_t;

	localparam logic [1:0] CMD_ENQ = 2'd0;
	localparam logic [1:0] CMD_DEQ = 2'd1;
	localparam logic [1:0] CMD_CLR = 2'd2;

	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_OVF = 2'd1;
	localparam logic [1:0] STATUS_UNF = 2'd2;

	localparam logic [1:0] LEVEL_NONE = 2'd0;
	localparam logic [1:0] LEVEL_ONE  = 2'd1;
	localparam logic [1:0] LEVEL_TWO  = 2'd2;

	// map a level code to a queue index; anything but one or two is level three
	function automatic queue_idx_t level_to_queue(input logic [1:0] lvl);
		queue_idx_t q;
		case (lvl)
			LEVEL_ONE: q = 2'd0;
			LEVEL_TWO: q = 2'd1;
			default:   q = 2'd2;
		endcase
		return q;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tlpf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_ctrl: handshake controller
// Tracks the output slot and issues the commit command to the datapath.
// ----------------------------------------------------------------------------
module tlpf_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      commit
);
	import tlpf_pkg::*;

	typedef enum logic {
		ST_EMPTY,
		ST_FULL
	} state_t;

	state_t state_q;

	// slot frees as it is taken, so a new item may enter in the same cycle
	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign commit    = in_valid && in_ready;
	assign out_valid = (state_q == ST_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			case (state_q)
				ST_EMPTY: begin
					if (commit) state_q <= ST_FULL;
				end
				ST_FULL: begin
					if (out_ready && !commit) state_q <= ST_EMPTY;
				end
				default: state_q <= ST_EMPTY;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/tlpf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_dp: priority FIFO datapath
// Pointer registers, shared entry memory and the result register.
// ----------------------------------------------------------------------------
module tlpf_dp #(
	parameter int DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       commit,
	input  wire logic [1:0] cmd,
	input  wire logic [1:0] level,
	input  wire logic [7:0] data_in,
	output logic      [7:0] data_out,
	output logic      [1:0] status,
	output logic      [1:0] served_level,
	output logic            empty_one,
	output logic            empty_two,
	output logic            empty_three
);
	import tlpf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AW = $clog2(NumLevels * DEPTH);
	localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

	logic [PW-1:0] rd_ptr_q [NumLevels];
	logic [PW-1:0] wr_ptr_q [NumLevels];
	logic [PW-1:0] rd_nx    [NumLevels];
	logic [PW-1:0] wr_nx    [NumLevels];
	logic [NumLevels-1:0] empty_now, full_now, empty_nx;

	logic [7:0] mem [NumLevels * DEPTH];

	queue_idx_t qsel, deq_q;
	logic       any_data;
	logic       wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [1:0] status_d, served_d;

	logic [7:0] data_q;
	logic [1:0] status_q, served_q;
	logic [NumLevels-1:0] empty_q;

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
		return (p == LastPtr) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot_addr(input queue_idx_t q, input logic [PW-1:0] p);
		return AW'(q) * AW'(DEPTH) + AW'(p);
	endfunction

	always_comb begin
		for (int i = 0; i < NumLevels; i++) begin
			empty_now[i] = (rd_ptr_q[i] == wr_ptr_q[i]);
			full_now[i]  = (advance(wr_ptr_q[i]) == rd_ptr_q[i]);
		end
	end

	// level one wins a dequeue if it holds data, then level two, then level three
	always_comb begin
		qsel     = level_to_queue(level);
		any_data = ~&empty_now;
		if (!empty_now[0])      deq_q = 2'd0;
		else if (!empty_now[1]) deq_q = 2'd1;
		else                    deq_q = 2'd2;
	end

	always_comb begin
		for (int i = 0; i < NumLevels; i++) begin
			rd_nx[i] = rd_ptr_q[i];
			wr_nx[i] = wr_ptr_q[i];
		end
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		status_d = STATUS_OK;
		served_d = LEVEL_NONE;
		case (cmd)
			CMD_ENQ: begin
				if (full_now[qsel]) begin
					status_d = STATUS_OVF;
				end else begin
					wr_en       = 1'b1;
					wr_nx[qsel] = advance(wr_ptr_q[qsel]);
				end
			end
			CMD_DEQ: begin
				if (any_data) begin
					rd_en        = 1'b1;
					rd_nx[deq_q] = advance(rd_ptr_q[deq_q]);
					served_d     = deq_q + 2'd1;
				end else begin
					status_d = STATUS_UNF;
				end
			end
			CMD_CLR: begin
				rd_nx[qsel] = wr_ptr_q[qsel];
			end
			default: begin
			end
		endcase
		for (int i = 0; i < NumLevels; i++) begin
			empty_nx[i] = (rd_nx[i] == wr_nx[i]);
		end
		wr_addr = slot_addr(qsel, wr_ptr_q[qsel]);
		rd_addr = slot_addr(deq_q, rd_ptr_q[deq_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumLevels; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
			end
		end else if (commit) begin
			for (int i = 0; i < NumLevels; i++) begin
				rd_ptr_q[i] <= rd_nx[i];
				wr_ptr_q[i] <= wr_nx[i];
			end
		end
	end

	// entry memory with its read port landing in the result register
	always_ff @(posedge clk) begin
		if (commit) begin
			if (wr_en) mem[wr_addr] <= data_in;
			data_q   <= rd_en ? mem[rd_addr] : 8'd0;
			status_q <= status_d;
			served_q <= served_d;
			empty_q  <= empty_nx;
		end
	end

	assign data_out     = data_q;
	assign status       = status_q;
	assign served_level = served_q;
	assign empty_one    = empty_q[0];
	assign empty_two    = empty_q[1];
	assign empty_three  = empty_q[2];

endmodule
`default_nettype wire

FILE: hw/rtl/three_level_priority_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_priority_fifo: strict priority queue over three byte FIFOs
// Enqueue, dequeue and clear commands with one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries cmd, level and data_in. An
//   enqueue stores data_in in the FIFO of its level (level 1 or 2, anything
//   else level 3); a dequeue takes the oldest byte from the first of levels
//   1, 2, 3 that holds data; a clear empties the named level.
//   Output channel (out_valid/out_ready) returns one item per command:
//   data_out, status, served_level and the three empty flags after the step.
//   The result is registered and valid in the cycle after the command is accepted.
//   Throughput: one command per cycle while the receiver takes results; the
//   single result register and the one write / one read entry memory set
//   this figure.
//   A stalled receiver holds the result; in_ready drops until it is taken,
//   and rises again in the cycle it is taken.
//   Each level keeps one slot free, so it holds DEPTH-1 bytes. Overflow and
//   underflow report an error status and leave the state untouched.
//   Reset empties all three levels; entry contents are not cleared.
// ----------------------------------------------------------------------------
module three_level_priority_fifo #(
	parameter int DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic [1:0] level,
	input  wire logic [7:0] data_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] data_out,
	output logic      [1:0] status,
	output logic      [1:0] served_level,
	output logic            empty_one,
	output logic            empty_two,
	output logic            empty_three
);
	import tlpf_pkg::*;

	logic commit;

	// controller: owns the handshake and the output slot
	tlpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.commit    (commit)
	);

	// datapath: pointers, entry memory and result register
	tlpf_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.cmd          (cmd),
		.level        (level),
		.data_in      (data_in),
		.data_out     (data_out),
		.status       (status),
		.served_level (served_level),
		.empty_one    (empty_one),
		.empty_two    (empty_two),
		.empty_three  (empty_three)
	);

	// underflow only when every level is empty
	a_unf_all_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_UNF |-> empty_one && empty_two && empty_three)
		else $error("underflow reported with data present");

	// a served byte always carries an ok status
	a_served_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && served_level != LEVEL_NONE |-> status == STATUS_OK)
		else $error("served level with error status");

	// non-zero data only comes from a dequeue
	a_data_served: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_out != 8'd0 |-> served_level != LEVEL_NONE)
		else $error("data without a served level");

	// an accepted item produces a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

endmodule
`default_nettype wire
